### design/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define DQ_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dq_pkg.sv
// Types and constants shared by the double-ended queue modules.
package dq_pkg;

    localparam int DATA_W = 32;
    localparam int ENTRY_COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_POP_FRONT  = 2'd1,
        OP_PUSH_BACK  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [DATA_W-1:0] push_value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        status_t                  status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     is_empty;
    } out_t;

    // one-cycle action that every cell applies
    typedef struct packed {
        logic    push_front;
        logic    pop_front;
        logic    push_back;
        logic    pop_back;
        status_t status;
    } ctrl_t;

endpackage

### design/dq_cell.sv
// One storage cell of the deque chain: holds the value at its position from the front.
module dq_cell
    import dq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
)
(
    input  logic                     clk,
    input  ctrl_t                    ctrl,
    input  logic [CNT_W-1:0]         count,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic signed [DATA_W-1:0] prev_val,
    input  logic signed [DATA_W-1:0] next_val,
    input  logic signed [DATA_W-1:0] tap_in,
    output logic signed [DATA_W-1:0] val,
    output logic signed [DATA_W-1:0] tap_out
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] LAST_C = CNT_W'(IDX + 1);

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.push_front)
        begin
            // whole chain moves one place toward the back
            val_next = prev_val;
        end
        else if (ctrl.pop_front)
        begin
            val_next = next_val;
        end
        else if (ctrl.push_back && count == IDX_C)
        begin
            val_next = push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    // last occupied cell drops its value onto the back-pop tap line
    assign tap_out = tap_in | ((count == LAST_C) ? val_reg : '0);

endmodule

### design/dq_ctrl.sv
// Occupancy count and per-beat action decode for the deque.
module dq_ctrl
    import dq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  op_t              operation,
    output ctrl_t            ctrl,
    output logic [CNT_W-1:0] count,
    output logic [CNT_W-1:0] count_after
);

    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;

    assign full  = (count_reg == FULL_C);
    assign empty = (count_reg == '0);

    always_comb
    begin
        ctrl = '{push_front: 1'b0, pop_front: 1'b0, push_back: 1'b0,
                 pop_back: 1'b0, status: ST_DONE};
        case (operation)
            OP_PUSH_FRONT:
            begin
                if (full) ctrl.status = ST_FULL;
                else      ctrl.push_front = take;
            end
            OP_PUSH_BACK:
            begin
                if (full) ctrl.status = ST_FULL;
                else      ctrl.push_back = take;
            end
            OP_POP_FRONT:
            begin
                if (empty) ctrl.status = ST_EMPTY;
                else       ctrl.pop_front = take;
            end
            OP_POP_BACK:
            begin
                if (empty) ctrl.status = ST_EMPTY;
                else       ctrl.pop_back = take;
            end
            default:
            begin
                ctrl.status = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push_front || ctrl.push_back)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop_front || ctrl.pop_back)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count       = count_reg;
    assign count_after = count_next;

endmodule

### design/double_ended_queue.sv
// Top level of the bounded double-ended queue built as a chain of cells.
//
// Usage:
//   Command channel: drive cmd and raise start; a beat is taken at a rising
//   edge with start high and busy low. busy stays low, so a new command can
//   be issued in every cycle.
//   Result channel: one result per command, shown on result for exactly one
//   cycle with done high, the cycle after the command beat. Throughput 1
//   command per cycle.
//   Values live in a row of CAPACITY cells ordered front to back. Push/pop
//   at the front shifts the whole row one place; push at the back writes
//   the cell at the current count; pop at the back takes the last occupied
//   cell through a tap line running down the row.
//   A push when full returns status full, a pop when empty returns status
//   empty; neither changes the stored values or the count.
//   Reset clears the count and the result strobe; cell contents are not
//   cleared and are only read after being written.
//   The receiver cannot stall: each result must be taken in its cycle.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  cmd,
    output logic done,
    output out_t result
);

`include "double_ended_queue_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    ctrl_t            ctrl;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_after;
    logic             take;

    logic signed [DATA_W-1:0] vals [CAPACITY];
    logic signed [DATA_W-1:0] taps [CAPACITY+1];

    logic                     done_reg;
    logic                     done_next;
    out_t                     result_reg;
    out_t                     result_next;
    logic signed [DATA_W-1:0] popped;
    logic [CNT_W+ENTRY_COUNT_W-1:0] count_wide;

    assign busy = 1'b0;
    assign take = start && !busy;

    dq_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .operation   (cmd.operation),
        .ctrl        (ctrl),
        .count       (count),
        .count_after (count_after)
    );

    assign taps[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] prev_v;
        logic signed [DATA_W-1:0] next_v;

        if (i == 0)
        begin : g_head
            assign prev_v = cmd.push_value;
        end
        else
        begin : g_mid
            assign prev_v = vals[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_v = vals[i];
        end
        else
        begin : g_body
            assign next_v = vals[i+1];
        end

        dq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count),
            .push_value (cmd.push_value),
            .prev_val   (prev_v),
            .next_val   (next_v),
            .tap_in     (taps[i]),
            .val        (vals[i]),
            .tap_out    (taps[i+1])
        );
    end

    always_comb
    begin
        if (ctrl.pop_front)     popped = vals[0];
        else if (ctrl.pop_back) popped = taps[CAPACITY];
        else                    popped = '0;
    end

    // entry count is the count after this command, truncated to the port width
    assign count_wide = {{ENTRY_COUNT_W{1'b0}}, count_after};

    always_comb
    begin
        result_next.popped_value = popped;
        result_next.status       = ctrl.status;
        result_next.entry_count  = count_wide[ENTRY_COUNT_W-1:0];
        result_next.is_empty     = (count_after == '0);
        done_next                = take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `DQ_ASSERT_NEXT(a_beat_strobe, start && !busy, done, "command beat without result strobe")
    `DQ_ASSERT_NEXT(a_no_extra, !(start && !busy), !done, "result strobe without command beat")
    `DQ_ASSERT(a_count_range, count <= CNT_W'(CAPACITY), "count above capacity")
    `DQ_ASSERT(a_refuse_hold,
        !done || result.status == ST_DONE || count == $past(count), "refused beat moved count")

endmodule

### dv/dq_checker.sv
// Scoreboard for the double-ended queue: tracks commands, predicts results, compares them.
module dq_checker
    import dq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  in_t  cmd,
    input  logic done,
    input  out_t result,
    output int   fail_count,
    output int   pending_count
);

    localparam int CAPACITY = 64;

    // shadow of the queue contents; 6-bit indexes wrap modulo CAPACITY on their own
    logic signed [DATA_W-1:0] shadow_slots [CAPACITY];
    logic [5:0]               head_idx;
    logic [5:0]               tail_idx;
    logic [ENTRY_COUNT_W-1:0] held_count;

    out_t results_due [$];
    int   mismatches;
    int   lines_shown;

    assign fail_count = mismatches;

    task automatic flag_mismatch(string what, longint got, longint want);
        mismatches++;
        if (lines_shown < 100)
        begin
            lines_shown++;
            $display("checker: %s got %0d want %0d at %0t", what, got, want, $realtime);
        end
    endtask

    function automatic out_t apply_command(in_t c);
        out_t r;
        r = '0;
        r.status = ST_DONE;
        case (c.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held_count >= CAPACITY)
                    r.status = ST_FULL;
                else if (c.operation == OP_PUSH_FRONT)
                begin
                    head_idx = head_idx - 6'd1;
                    shadow_slots[head_idx] = c.push_value;
                    held_count++;
                end
                else
                begin
                    shadow_slots[tail_idx] = c.push_value;
                    tail_idx = tail_idx + 6'd1;
                    held_count++;
                end
            end
            default:
            begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else if (c.operation == OP_POP_FRONT)
                begin
                    r.popped_value = shadow_slots[head_idx];
                    head_idx = head_idx + 6'd1;
                    held_count--;
                end
                else
                begin
                    tail_idx = tail_idx - 6'd1;
                    r.popped_value = shadow_slots[tail_idx];
                    held_count--;
                end
            end
        endcase
        r.entry_count = held_count;
        r.is_empty = (held_count == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            head_idx = '0;
            tail_idx = '0;
            held_count = '0;
            results_due.delete();
            pending_count <= 0;
        end
        else
        begin
            // queue the prediction first so a result in the same beat still finds it
            if (start && !busy)
                results_due.push_back(apply_command(cmd));
            if (done)
            begin
                if (results_due.size() == 0)
                    flag_mismatch("result beat with none due", 1, 0);
                else
                begin
                    want = results_due.pop_front();
                    if (result.popped_value !== want.popped_value)
                        flag_mismatch("popped_value", result.popped_value, want.popped_value);
                    if (result.status !== want.status)
                        flag_mismatch("status", result.status, want.status);
                    if (result.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", result.entry_count, want.entry_count);
                    if (result.is_empty !== want.is_empty)
                        flag_mismatch("is_empty", result.is_empty, want.is_empty);
                end
            end
            pending_count <= results_due.size();
        end
    end

    initial
    begin
        mismatches = 0;
        lines_shown = 0;
    end

endmodule

### dv/testbench.sv
// Top of the double-ended queue testbench: clock, reset, command stimulus and verdict.
module testbench;
    import dq_pkg::*;

    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    in_t  cmd;
    logic done;
    out_t result;
    int   fail_count;
    int   pending_count;
    int   sender_idle_pct;

    double_ended_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    dq_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one command beat; the task leaves start high, and hold_off lowers it
    task automatic issue(op_t op, logic signed [DATA_W-1:0] value);
        @(negedge clk);
        start <= 1'b1;
        cmd <= '{operation: op, push_value: value};
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
            cmd <= '{operation: op_t'($urandom_range(0, 3)), push_value: $urandom};
        end
    endtask

    task automatic wait_drained();
        hold_off(1);
        while (pending_count != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t pick_op(int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    // push_pct steers the fill level: high runs into full, low runs into empty
    task automatic random_run(int items, int push_pct);
        repeat (items)
        begin
            // each cycle idles with probability sender_idle_pct
            while ($urandom_range(0, 99) < sender_idle_pct)
                hold_off(1);
            issue(pick_op(push_pct), pick_value());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        sender_idle_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty pops, pointer wrap below slot zero, value extremes, both ends
        issue(OP_POP_FRONT, 32'sd5);
        issue(OP_POP_BACK, -32'sd5);
        issue(OP_PUSH_FRONT, MOST_NEG);
        issue(OP_POP_BACK, '0);
        issue(OP_PUSH_BACK, MOST_POS);
        issue(OP_PUSH_FRONT, '0);
        issue(OP_PUSH_BACK, -1);
        issue(OP_PUSH_FRONT, 32'sh5555_5555);
        issue(OP_PUSH_BACK, 32'shAAAA_AAAA);
        issue(OP_POP_FRONT, -1);
        issue(OP_POP_BACK, MOST_POS);
        issue(OP_POP_FRONT, MOST_NEG);
        issue(OP_POP_BACK, '0);
        issue(OP_POP_FRONT, '0);
        issue(OP_POP_BACK, '0);
        issue(OP_POP_FRONT, '0);
        issue(OP_PUSH_BACK, 32'sd1);
        issue(OP_POP_BACK, '0);
        issue(OP_PUSH_FRONT, 32'sd2);
        issue(OP_POP_FRONT, '0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 70 : 0;
            random_run(120, 85);
            random_run(60, 50);
            random_run(120, 15);
            random_run(80, 75);
            random_run(80, 25);
            // let the queue settle completely before the next phase
            wait_drained();
        end

        wait_drained();
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/dq_pkg.sv
design/dq_cell.sv
design/dq_ctrl.sv
design/double_ended_queue.sv
dv/dq_checker.sv
dv/testbench.sv
